// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_ON(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/pot_pkg.sv =====
// ----------------------------------------------------------------------------
// pot_pkg
// Orientation, request and register codes of the placement orientation
// transform.
// ----------------------------------------------------------------------------
package pot_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [2:0] {
      ORIENT_N,
      ORIENT_W,
      ORIENT_S,
      ORIENT_E,
      ORIENT_FN,
      ORIENT_FE,
      ORIENT_FS,
      ORIENT_FW
   } orient_type;

   typedef enum logic [1:0] {
      REQ_POINT_FWD,
      REQ_POINT_REV,
      REQ_BOX_FWD,
      REQ_BOX_REV
   } req_kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORIENTATION,
      CSR_PLACE_X,
      CSR_PLACE_Y,
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_CELL_WIDTH,
      CSR_CELL_HEIGHT
   } csr_index_type;

endpackage

// ===== design/pot_csr.sv =====
// ----------------------------------------------------------------------------
// pot_csr
// Configuration registers and the placement offset register. The offset is
// formed from the next register values so it is current with them.
// ----------------------------------------------------------------------------
module pot_csr import pot_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata,
   output orient_type                orient,
   output logic [COORD_BITS-1:0]     dx,
   output logic [COORD_BITS-1:0]     dy,
   output logic                      ofs_ovf
);

   localparam int W = COORD_BITS;

   orient_type   orient_ff, orient_in;
   logic [W-1:0] place_x_ff, place_x_in;
   logic [W-1:0] place_y_ff, place_y_in;
   logic [W-1:0] origin_x_ff, origin_x_in;
   logic [W-1:0] origin_y_ff, origin_y_in;
   logic [W-2:0] width_ff, width_in;
   logic [W-2:0] height_ff, height_in;
   logic [W-1:0] dx_ff, dx_in;
   logic [W-1:0] dy_ff, dy_in;
   logic         ovf_ff, ovf_in;

   // result carries the signed overflow flag in its top bit
   function automatic logic [W:0] add_f(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] r;
      r = {a[W-1], a} + {b[W-1], b};
      return {r[W] ^ r[W-1], r[W-1:0]};
   endfunction

   function automatic logic [W:0] sub_f(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] r;
      r = {a[W-1], a} - {b[W-1], b};
      return {r[W] ^ r[W-1], r[W-1:0]};
   endfunction

   always_comb begin
      orient_in   = orient_ff;
      place_x_in  = place_x_ff;
      place_y_in  = place_y_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORIENTATION: orient_in   = orient_type'(csr_wdata[2:0]);
            CSR_PLACE_X:     place_x_in  = csr_wdata;
            CSR_PLACE_Y:     place_y_in  = csr_wdata;
            CSR_ORIGIN_X:    origin_x_in = csr_wdata;
            CSR_ORIGIN_Y:    origin_y_in = csr_wdata;
            CSR_CELL_WIDTH:  width_in    = csr_wdata[W-2:0];
            CSR_CELL_HEIGHT: height_in   = csr_wdata[W-2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [W:0]   tx, ty, rx, ry;
      logic [W-1:0] wext, hext;
      wext = {1'b0, width_in};
      hext = {1'b0, height_in};
      tx   = '0;
      ty   = '0;
      rx   = '0;
      ry   = '0;
      case (orient_in)
         ORIENT_N: begin
            rx = sub_f(place_x_in, origin_x_in);
            ry = sub_f(place_y_in, origin_y_in);
         end
         ORIENT_W: begin
            tx = add_f(place_x_in, origin_y_in);
            rx = add_f(tx[W-1:0], hext);
            ry = sub_f(place_y_in, origin_x_in);
         end
         ORIENT_S: begin
            tx = add_f(place_x_in, origin_x_in);
            rx = add_f(tx[W-1:0], wext);
            ty = add_f(place_y_in, origin_y_in);
            ry = add_f(ty[W-1:0], hext);
         end
         ORIENT_E: begin
            rx = sub_f(place_x_in, origin_y_in);
            ty = add_f(place_y_in, origin_x_in);
            ry = add_f(ty[W-1:0], wext);
         end
         ORIENT_FN: begin
            tx = add_f(place_x_in, origin_x_in);
            rx = add_f(tx[W-1:0], wext);
            ry = sub_f(place_y_in, origin_y_in);
         end
         ORIENT_FE: begin
            tx = add_f(place_x_in, origin_y_in);
            rx = add_f(tx[W-1:0], hext);
            ty = add_f(place_y_in, origin_x_in);
            ry = add_f(ty[W-1:0], wext);
         end
         ORIENT_FS: begin
            rx = sub_f(place_x_in, origin_x_in);
            ty = add_f(place_y_in, origin_y_in);
            ry = add_f(ty[W-1:0], hext);
         end
         default: begin
            rx = sub_f(place_x_in, origin_y_in);
            ry = sub_f(place_y_in, origin_x_in);
         end
      endcase
      dx_in  = rx[W-1:0];
      dy_in  = ry[W-1:0];
      ovf_in = tx[W] | ty[W] | rx[W] | ry[W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff   <= ORIENT_N;
         place_x_ff  <= '0;
         place_y_ff  <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         dx_ff       <= '0;
         dy_ff       <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         orient_ff   <= orient_in;
         place_x_ff  <= place_x_in;
         place_y_ff  <= place_y_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         ovf_ff      <= ovf_in;
      end
   end

   assign orient  = orient_ff;
   assign dx      = dx_ff;
   assign dy      = dy_ff;
   assign ofs_ovf = ovf_ff;

endmodule

// ===== design/pot_corner.sv =====
// ----------------------------------------------------------------------------
// pot_corner
// Maps one corner forward or in reverse under the placement orientation.
// ----------------------------------------------------------------------------
module pot_corner import pot_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  orient_type            orient,
   input  logic                  rev,
   input  logic [COORD_BITS-1:0] dx,
   input  logic [COORD_BITS-1:0] dy,
   input  logic [COORD_BITS-1:0] x,
   input  logic [COORD_BITS-1:0] y,
   output logic [COORD_BITS-1:0] rx,
   output logic [COORD_BITS-1:0] ry,
   output logic                  ovf
);

   localparam int W = COORD_BITS;

   logic [W:0] rx_r, ry_r;

   function automatic logic [W:0] add_f(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] r;
      r = {a[W-1], a} + {b[W-1], b};
      return {r[W] ^ r[W-1], r[W-1:0]};
   endfunction

   function automatic logic [W:0] sub_f(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] r;
      r = {a[W-1], a} - {b[W-1], b};
      return {r[W] ^ r[W-1], r[W-1:0]};
   endfunction

   always_comb begin
      case (orient)
         ORIENT_N: begin
            rx_r = rev ? sub_f(x, dx) : add_f(dx, x);
            ry_r = rev ? sub_f(y, dy) : add_f(dy, y);
         end
         ORIENT_W: begin
            rx_r = rev ? sub_f(y, dy) : sub_f(dx, y);
            ry_r = rev ? sub_f(dx, x) : add_f(dy, x);
         end
         ORIENT_S: begin
            rx_r = sub_f(dx, x);
            ry_r = sub_f(dy, y);
         end
         ORIENT_E: begin
            rx_r = rev ? sub_f(dy, y) : add_f(dx, y);
            ry_r = rev ? sub_f(x, dx) : sub_f(dy, x);
         end
         ORIENT_FN: begin
            rx_r = sub_f(dx, x);
            ry_r = rev ? sub_f(y, dy) : add_f(dy, y);
         end
         ORIENT_FE: begin
            rx_r = rev ? sub_f(dy, y) : sub_f(dx, y);
            ry_r = rev ? sub_f(dx, x) : sub_f(dy, x);
         end
         ORIENT_FS: begin
            rx_r = rev ? sub_f(x, dx) : add_f(dx, x);
            ry_r = sub_f(dy, y);
         end
         default: begin
            rx_r = rev ? sub_f(y, dy) : add_f(dx, y);
            ry_r = rev ? sub_f(x, dx) : add_f(dy, x);
         end
      endcase
   end

   assign rx  = rx_r[W-1:0];
   assign ry  = ry_r[W-1:0];
   assign ovf = rx_r[W] | ry_r[W];

endmodule

// ===== design/placement_orient_transform.sv =====
// ----------------------------------------------------------------------------
// placement_orient_transform
// Maps points and boxes between a cell frame and the placed frame.
// ----------------------------------------------------------------------------
// One request per clock unless the response side stalls: a request is
// held in the input register, both corners are mapped by one add or subtract
// each against the stored placement offset, box corners are ordered by a
// signed compare, and the result waits in the output register. The offset is
// recomputed in the cycle of each configuration write, so requests may follow
// a write at once. Results wrap at COORD_BITS bits; overflow flags any wrap in
// the offset or the mapping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module placement_orient_transform import pot_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [COORD_BITS-1:0]     req_in_x0,
   input  logic [COORD_BITS-1:0]     req_in_y0,
   input  logic [COORD_BITS-1:0]     req_in_x1,
   input  logic [COORD_BITS-1:0]     req_in_y1,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COORD_BITS-1:0]     rsp_out_x0,
   output logic [COORD_BITS-1:0]     rsp_out_y0,
   output logic [COORD_BITS-1:0]     rsp_out_x1,
   output logic [COORD_BITS-1:0]     rsp_out_y1,
   output logic                      rsp_overflow,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata
);

   localparam int W = COORD_BITS;

   orient_type   orient;
   logic [W-1:0] dx, dy;
   logic         ofs_ovf;

   logic         a_valid_ff, a_valid_in;
   req_kind_type a_kind_ff;
   logic [W-1:0] a_x0_ff, a_y0_ff, a_x1_ff, a_y1_ff;

   logic         b_valid_ff, b_valid_in;
   logic         b_box_ff;
   logic [W-1:0] b_x0_ff, b_y0_ff, b_x1_ff, b_y1_ff;
   logic         b_ovf_ff;

   logic         take_b, rev, is_box;
   logic [W-1:0] ax, ay, cx, cy;
   logic         a_ovf, c_ovf;
   logic [W-1:0] lo_x, lo_y, hi_x, hi_y;
   logic         ovf_in;

   pot_csr #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .orient    (orient),
      .dx        (dx),
      .dy        (dy),
      .ofs_ovf   (ofs_ovf)
   );

   assign rev    = (a_kind_ff == REQ_POINT_REV) || (a_kind_ff == REQ_BOX_REV);
   assign is_box = (a_kind_ff == REQ_BOX_FWD) || (a_kind_ff == REQ_BOX_REV);

   pot_corner #(.COORD_BITS(COORD_BITS)) u_corner0 (
      .orient (orient),
      .rev    (rev),
      .dx     (dx),
      .dy     (dy),
      .x      (a_x0_ff),
      .y      (a_y0_ff),
      .rx     (ax),
      .ry     (ay),
      .ovf    (a_ovf)
   );

   pot_corner #(.COORD_BITS(COORD_BITS)) u_corner1 (
      .orient (orient),
      .rev    (rev),
      .dx     (dx),
      .dy     (dy),
      .x      (a_x1_ff),
      .y      (a_y1_ff),
      .rx     (cx),
      .ry     (cy),
      .ovf    (c_ovf)
   );

   always_comb begin
      if (!is_box) begin
         lo_x = ax;
         lo_y = ay;
         hi_x = '0;
         hi_y = '0;
      end else begin
         lo_x = ($signed(ax) < $signed(cx)) ? ax : cx;
         hi_x = ($signed(ax) < $signed(cx)) ? cx : ax;
         lo_y = ($signed(ay) < $signed(cy)) ? ay : cy;
         hi_y = ($signed(ay) < $signed(cy)) ? cy : ay;
      end
      ovf_in = ofs_ovf | a_ovf | (is_box & c_ovf);
   end

   assign take_b    = !b_valid_ff || rsp_ready;
   assign req_ready = !a_valid_ff || take_b;

   always_comb begin
      a_valid_in = req_ready ? req_valid : a_valid_ff;
      b_valid_in = take_b ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_kind_ff <= req_kind_type'(req_type);
         a_x0_ff   <= req_in_x0;
         a_y0_ff   <= req_in_y0;
         a_x1_ff   <= req_in_x1;
         a_y1_ff   <= req_in_y1;
      end
      if (take_b && a_valid_ff) begin
         b_box_ff <= is_box;
         b_x0_ff  <= lo_x;
         b_y0_ff  <= lo_y;
         b_x1_ff  <= hi_x;
         b_y1_ff  <= hi_y;
         b_ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid    = b_valid_ff;
   assign rsp_out_x0   = b_x0_ff;
   assign rsp_out_y0   = b_y0_ff;
   assign rsp_out_x1   = b_x1_ff;
   assign rsp_out_y1   = b_y1_ff;
   assign rsp_overflow = b_ovf_ff;

   `ASSERT_ON(a_moves_to_output, a_valid_ff && take_b |=> rsp_valid, "request lost between stages")
   `ASSERT_ON(point_upper_zero, rsp_valid && !b_box_ff |-> rsp_out_x1 == '0 && rsp_out_y1 == '0, "point result has nonzero upper corner")
   `ASSERT_ON(box_ordered, rsp_valid && b_box_ff |-> $signed(rsp_out_x0) <= $signed(rsp_out_x1) && $signed(rsp_out_y0) <= $signed(rsp_out_y1), "box result not ordered")
   `ASSERT_ALWAYS(empty_after_reset, reset |=> !rsp_valid && !a_valid_ff, "pipeline not empty after reset")

endmodule

// ===== bench/placement_orient_transform_tb.sv =====
// ----------------------------------------------------------------------------
// placement_orient_transform_tb
// Drives point and box requests through the orientation transform, first a
// directed table, then random requests in phases with a fresh placement
// setting per phase and varying idle/stall patterns on both channels. Every
// response is compared against the expected values of the typed table rows or
// against a local model of the offset, mapping, corner ordering and overflow rules.
// ----------------------------------------------------------------------------
module placement_orient_transform_tb import pot_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] CMAX = 32'h7fff_ffff;
   localparam logic [31:0] CMIN = 32'h8000_0000;
   localparam int RUN_LIMIT = 400000;
   localparam int PHASES = 8;
   localparam int PHASE_REQS = 188;

   typedef struct packed {
      req_kind_type kind;
      logic [31:0]  x0;
      logic [31:0]  y0;
      logic [31:0]  x1;
      logic [31:0]  y1;
   } coord_req_type;

   typedef struct packed {
      logic [31:0] x0;
      logic [31:0] y0;
      logic [31:0] x1;
      logic [31:0] y1;
      logic        ovf;
   } mapped_type;

   typedef struct packed {
      longint x;
      longint y;
   } corner_type;

   typedef struct {
      bit            wr;
      csr_index_type idx;
      logic [31:0]   val;
      coord_req_type rq;
      bit            typed;
      mapped_type    want;
   } plan_row_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_type = '0;
   logic [31:0]               req_in_x0 = '0;
   logic [31:0]               req_in_y0 = '0;
   logic [31:0]               req_in_x1 = '0;
   logic [31:0]               req_in_y1 = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [31:0]               rsp_out_x0;
   logic [31:0]               rsp_out_y0;
   logic [31:0]               rsp_out_x1;
   logic [31:0]               rsp_out_y1;
   logic                      rsp_overflow;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0]               csr_wdata = '0;

   orient_type cur_orient = ORIENT_N;
   longint cur_px = 0, cur_py = 0, cur_ox = 0, cur_oy = 0, cur_w = 0, cur_h = 0;
   bit wrap_seen;

   mapped_type   mapped_queue[$];
   mapped_type   head;
   plan_row_type plan[$];
   int           mismatches = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   placement_orient_transform dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_in_x0    (req_in_x0),
      .req_in_y0    (req_in_y0),
      .req_in_x1    (req_in_x1),
      .req_in_y1    (req_in_y1),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_x0   (rsp_out_x0),
      .rsp_out_y0   (rsp_out_y0),
      .rsp_out_x1   (rsp_out_x1),
      .rsp_out_y1   (rsp_out_y1),
      .rsp_overflow (rsp_overflow),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint fold(longint v);
      longint w;
      w = longint'($signed(v[31:0]));
      if (w != v) wrap_seen = 1'b1;
      return w;
   endfunction

   function automatic longint cadd(longint a, longint b);
      return fold(a + b);
   endfunction

   function automatic longint csub(longint a, longint b);
      return fold(a - b);
   endfunction

   function automatic corner_type map_corner(bit rev, longint dx, longint dy,
                                             longint x, longint y);
      corner_type p;
      if (!rev) begin
         case (cur_orient)
            ORIENT_N:  begin p.x = cadd(dx, x); p.y = cadd(dy, y); end
            ORIENT_W:  begin p.x = csub(dx, y); p.y = cadd(dy, x); end
            ORIENT_S:  begin p.x = csub(dx, x); p.y = csub(dy, y); end
            ORIENT_E:  begin p.x = cadd(dx, y); p.y = csub(dy, x); end
            ORIENT_FN: begin p.x = csub(dx, x); p.y = cadd(dy, y); end
            ORIENT_FE: begin p.x = csub(dx, y); p.y = csub(dy, x); end
            ORIENT_FS: begin p.x = cadd(dx, x); p.y = csub(dy, y); end
            ORIENT_FW: begin p.x = cadd(dx, y); p.y = cadd(dy, x); end
         endcase
      end else begin
         case (cur_orient)
            ORIENT_N:  begin p.x = csub(x, dx); p.y = csub(y, dy); end
            ORIENT_W:  begin p.x = csub(y, dy); p.y = csub(dx, x); end
            ORIENT_S:  begin p.x = csub(dx, x); p.y = csub(dy, y); end
            ORIENT_E:  begin p.x = csub(dy, y); p.y = csub(x, dx); end
            ORIENT_FN: begin p.x = csub(dx, x); p.y = csub(y, dy); end
            ORIENT_FE: begin p.x = csub(dy, y); p.y = csub(dx, x); end
            ORIENT_FS: begin p.x = csub(x, dx); p.y = csub(dy, y); end
            ORIENT_FW: begin p.x = csub(y, dy); p.y = csub(x, dx); end
         endcase
      end
      return p;
   endfunction

   function automatic mapped_type transform_coords(coord_req_type rq);
      longint     dx, dy;
      corner_type a, c;
      mapped_type r;
      bit         rev, box;
      rev = (rq.kind == REQ_POINT_REV) || (rq.kind == REQ_BOX_REV);
      box = (rq.kind == REQ_BOX_FWD) || (rq.kind == REQ_BOX_REV);
      wrap_seen = 1'b0;
      case (cur_orient)
         ORIENT_N:  begin dx = csub(cur_px, cur_ox); dy = csub(cur_py, cur_oy); end
         ORIENT_W:  begin
            dx = cadd(cadd(cur_px, cur_oy), cur_h); dy = csub(cur_py, cur_ox);
         end
         ORIENT_S:  begin
            dx = cadd(cadd(cur_px, cur_ox), cur_w); dy = cadd(cadd(cur_py, cur_oy), cur_h);
         end
         ORIENT_E:  begin
            dx = csub(cur_px, cur_oy); dy = cadd(cadd(cur_py, cur_ox), cur_w);
         end
         ORIENT_FN: begin
            dx = cadd(cadd(cur_px, cur_ox), cur_w); dy = csub(cur_py, cur_oy);
         end
         ORIENT_FE: begin
            dx = cadd(cadd(cur_px, cur_oy), cur_h); dy = cadd(cadd(cur_py, cur_ox), cur_w);
         end
         ORIENT_FS: begin
            dx = csub(cur_px, cur_ox); dy = cadd(cadd(cur_py, cur_oy), cur_h);
         end
         ORIENT_FW: begin dx = csub(cur_px, cur_oy); dy = csub(cur_py, cur_ox); end
      endcase
      a = map_corner(rev, dx, dy, longint'($signed(rq.x0)), longint'($signed(rq.y0)));
      r.x1 = '0;
      r.y1 = '0;
      if (box) begin
         c = map_corner(rev, dx, dy, longint'($signed(rq.x1)), longint'($signed(rq.y1)));
         if (a.x < c.x) begin
            r.x1 = c.x[31:0];
         end else begin
            r.x1 = a.x[31:0];
            a.x = c.x;
         end
         if (a.y < c.y) begin
            r.y1 = c.y[31:0];
         end else begin
            r.y1 = a.y[31:0];
            a.y = c.y;
         end
      end
      r.x0 = a.x[31:0];
      r.y0 = a.y[31:0];
      r.ovf = wrap_seen;
      return r;
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(9))
         0: return CMAX;
         1: return CMIN;
         2: return '0;
         3, 4, 5: return $urandom_range(2000) - 1000;
         default: return $urandom();
      endcase
   endfunction

   function automatic void add_row(bit wr, csr_index_type idx, logic [31:0] val,
                                   req_kind_type k, logic [31:0] x0, logic [31:0] y0,
                                   logic [31:0] x1, logic [31:0] y1, bit typed,
                                   logic [31:0] e0, logic [31:0] e1, logic [31:0] e2,
                                   logic [31:0] e3, logic eo);
      plan_row_type row;
      row.wr = wr;
      row.idx = idx;
      row.val = val;
      row.rq.kind = k;
      row.rq.x0 = x0;
      row.rq.y0 = y0;
      row.rq.x1 = x1;
      row.rq.y1 = y1;
      row.typed = typed;
      row.want.x0 = e0;
      row.want.y0 = e1;
      row.want.x1 = e2;
      row.want.y1 = e3;
      row.want.ovf = eo;
      plan.push_back(row);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_ORIENTATION: cur_orient = orient_type'(v[2:0]);
         CSR_PLACE_X:     cur_px = longint'($signed(v));
         CSR_PLACE_Y:     cur_py = longint'($signed(v));
         CSR_ORIGIN_X:    cur_ox = longint'($signed(v));
         CSR_ORIGIN_Y:    cur_oy = longint'($signed(v));
         CSR_CELL_WIDTH:  cur_w = longint'(v[30:0]);
         CSR_CELL_HEIGHT: cur_h = longint'(v[30:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drop valid and hold until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      while (mapped_queue.size() != 0) @(posedge clock);
   endtask

   task automatic send_request(coord_req_type rq, bit typed, mapped_type want);
      req_valid <= 1'b1;
      req_type <= rq.kind;
      req_in_x0 <= rq.x0;
      req_in_y0 <= rq.y0;
      req_in_x1 <= rq.x1;
      req_in_y1 <= rq.y1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed) mapped_queue.push_back(want);
      else mapped_queue.push_back(transform_coords(rq));
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (mapped_queue.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            head = mapped_queue.pop_front();
            check_field("out_x0", head.x0, rsp_out_x0);
            check_field("out_y0", head.y0, rsp_out_y0);
            check_field("out_x1", head.x1, rsp_out_x1);
            check_field("out_y1", head.y1, rsp_out_y1);
            check_field("overflow", 32'(head.ovf), 32'(rsp_overflow));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      coord_req_type rq;
      mapped_type    blank;
      logic [31:0]   ow;
      blank = '0;

      add_row(0, CSR_ORIENTATION, 0, REQ_POINT_FWD, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
      add_row(0, CSR_ORIENTATION, 0, REQ_POINT_FWD, CMAX, CMIN, 32'h1234_5678,
              32'hdead_beef, 1, CMAX, CMIN, 0, 0, 0);
      add_row(0, CSR_ORIENTATION, 0, REQ_POINT_REV, CMIN, CMAX, CMAX, CMIN,
              1, CMIN, CMAX, 0, 0, 0);
      add_row(0, CSR_ORIENTATION, 0, REQ_BOX_FWD, 5, -3, -7, 9, 1, -7, -3, 5, 9, 0);
      add_row(0, CSR_ORIENTATION, 0, REQ_BOX_REV, CMAX, CMAX, CMIN, CMIN,
              1, CMIN, CMIN, CMAX, CMAX, 0);
      add_row(1, CSR_PLACE_X, CMAX, REQ_POINT_FWD, 1, 0, 0, 0, 1, CMIN, 0, 0, 0, 1);
      add_row(1, CSR_ORIGIN_X, -1, REQ_POINT_FWD, 0, 0, 3, 3, 1, CMIN, 0, 0, 0, 1);
      add_row(1, CSR_PLACE_X, 1000, REQ_BOX_FWD, 10, 20, -30, 40, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIGIN_X, -20, REQ_POINT_REV, 55, -66, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_PLACE_Y, -500, REQ_BOX_REV, 100, 100, -100, -100, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIGIN_Y, 7, REQ_POINT_FWD, -8, 9, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_CELL_WIDTH, 32'hffff_ffff, REQ_BOX_FWD, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_CELL_HEIGHT, 32'h8000_0005, REQ_POINT_FWD, 3, 4, 0, 0,
              0, 0, 0, 0, 0, 0);
      add_row(1, CSR_CELL_WIDTH, 300, REQ_POINT_FWD, 12, 34, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIENTATION, ORIENT_W, REQ_POINT_FWD, 12, 34, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIENTATION, ORIENT_S, REQ_BOX_FWD, 1, 2, 50, 60, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIENTATION, ORIENT_E, REQ_POINT_REV, 700, -800, 0, 0,
              0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIENTATION, ORIENT_FN, REQ_BOX_REV, 40, 30, 20, 10, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIENTATION, ORIENT_FE, REQ_POINT_FWD, -5, 6, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIENTATION, ORIENT_FS, REQ_BOX_FWD, -9, -9, 9, 9, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIENTATION, ORIENT_FW, REQ_POINT_REV, 1234, 4321, 0, 0,
              0, 0, 0, 0, 0, 0);
      add_row(0, CSR_ORIENTATION, 0, REQ_BOX_REV, CMIN, CMAX, 17, -17, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_ORIENTATION, ORIENT_W, REQ_POINT_REV, 77, 88, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, CSR_ORIENTATION, 0, REQ_BOX_REV, CMAX, CMIN, CMIN, CMAX, 0, 0, 0, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].wr) begin
            settle();
            write_reg(plan[i].idx, plan[i].val);
            csr_we <= 1'b0;
         end
         send_request(plan[i].rq, plan[i].typed, plan[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         ow = $urandom();
         ow[2:0] = p[2:0];
         write_reg(CSR_ORIENTATION, ow);
         write_reg(CSR_PLACE_X, (p == 3) ? CMAX : (p == 6) ? CMIN : pick_coord());
         write_reg(CSR_PLACE_Y, (p == 3) ? CMAX : (p == 6) ? CMIN : pick_coord());
         write_reg(CSR_ORIGIN_X, (p == 3) ? CMAX : (p == 6) ? CMIN : pick_coord());
         write_reg(CSR_ORIGIN_Y, (p == 3) ? CMAX : (p == 6) ? CMIN : pick_coord());
         write_reg(CSR_CELL_WIDTH, (p == 3) ? CMAX : (p == 6) ? CMIN : pick_coord());
         write_reg(CSR_CELL_HEIGHT, (p == 3) ? CMAX : (p == 6) ? CMIN : pick_coord());
         csr_we <= 1'b0;
         repeat (PHASE_REQS) begin
            rq.kind = req_kind_type'($urandom_range(3));
            rq.x0 = pick_coord();
            rq.y0 = pick_coord();
            rq.x1 = pick_coord();
            rq.y1 = pick_coord();
            send_request(rq, 1'b0, blank);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/pot_pkg.sv
design/pot_csr.sv
design/pot_corner.sv
design/placement_orient_transform.sv
bench/placement_orient_transform_tb.sv
